// File: hw/rtl/kpd_pkg.sv
// Shared types and constants for the packet deframer.
// Used by the result and configuration interfaces and by every module of the block.
package kpd_pkg;

	localparam int MAX_BYTES = 95;

	localparam int POS_W = 7;
	localparam int TICK_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END = 2'd2;

	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd100;
	localparam logic [7:0] START_RST = 8'h01;
	localparam logic [7:0] END_RST = 8'd13;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_TOO_LONG = 3'd2;
	localparam logic [2:0] ST_SHORTER = 3'd3;
	localparam logic [2:0] ST_LONGER = 3'd4;
	localparam logic [2:0] ST_BAD_SUM = 3'd5;

	localparam logic [7:0] CHAR_OFFSET = 8'd32;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic       is_start;
		logic       is_end;
	} kpd_item_t;

	function automatic logic [7:0] check_value(input logic [7:0] s);
		logic [5:0] folded;
		folded = s[5:0] + {4'd0, s[7:6]};
		return {2'b00, folded} + CHAR_OFFSET;
	endfunction

endpackage

// File: hw/rtl/kpd_if.sv
// Channel interfaces of the deframer: input items, results and register writes.
// Depends on kpd_pkg.
interface kpd_item_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;
	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface kpd_result_if;
	import kpd_pkg::*;
	logic             valid;
	logic             ready;
	logic             kind;
	logic [POS_W-1:0] position;
	logic [7:0]       byte_value;
	logic [2:0]       status;
	logic [7:0]       packet_seq;
	logic [7:0]       packet_type;
	modport source (output valid, output kind, output position, output byte_value,
		output status, output packet_seq, output packet_type, input ready);
	modport sink (input valid, input kind, input position, input byte_value,
		input status, input packet_seq, input packet_type, output ready);
endinterface

interface kpd_cfg_if;
	import kpd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/kpd_front.sv
// Front end: configuration registers, request acceptance and character classification.
// Depends on kpd_pkg and kpd_if.
module kpd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	kpd_item_if.sink                   in_ch,
	kpd_cfg_if.sink                    cfg_ch,
	output kpd_pkg::kpd_item_t         push_item,
	output logic                       push_valid,
	input  logic                       push_ready,
	output logic [kpd_pkg::TICK_W-1:0] timeout_ticks
);
	import kpd_pkg::*;

	logic [TICK_W-1:0] timeout_q;
	logic [7:0]        start_q;
	logic [7:0]        end_q;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			start_q <= START_RST;
			end_q <= END_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_TIMEOUT: timeout_q <= cfg_ch.data;
				REG_START: start_q <= cfg_ch.data[7:0];
				REG_END: end_q <= cfg_ch.data[7:0];
				default: ;
			endcase
		end
	end

	assign timeout_ticks = timeout_q;
	assign in_ch.ready = push_ready;
	assign push_valid = in_ch.valid;

	always_comb begin
		push_item.func = in_ch.func;
		push_item.data_byte = in_ch.data_byte;
		push_item.is_start = (in_ch.data_byte == start_q);
		push_item.is_end = (in_ch.data_byte == end_q);
	end
endmodule

// File: hw/rtl/kpd_queue.sv
// Two-entry queue of classified requests between front and back.
// Depends on kpd_pkg.
module kpd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  kpd_pkg::kpd_item_t push_item,
	input  logic               push_valid,
	output logic               push_ready,
	output kpd_pkg::kpd_item_t pop_item,
	output logic               pop_valid,
	input  logic               pop_ready
);
	import kpd_pkg::*;

	kpd_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end
endmodule

// File: hw/rtl/kpd_back.sv
// Back end: packet state, length and checksum checks, and the result register.
// Depends on kpd_pkg and kpd_if.
module kpd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kpd_pkg::kpd_item_t         pop_item,
	input  logic                       pop_valid,
	output logic                       pop_ready,
	input  logic [kpd_pkg::TICK_W-1:0] timeout_ticks,
	kpd_result_if.source               out_ch
);
	import kpd_pkg::*;

	logic             in_packet_q;
	logic [POS_W-1:0] count_q;
	logic [TICK_W-1:0] tick_q;
	logic [7:0]       sum_q;
	logic [7:0]       sum_prev_q;
	logic [7:0]       last_q;
	logic [7:0]       len_q;
	logic [7:0]       seq_q;
	logic [7:0]       type_q;

	logic             out_valid_q;
	logic             kind_q;
	logic [POS_W-1:0] position_q;
	logic [7:0]       byte_value_q;
	logic [2:0]       status_q;
	logic [7:0]       seq_out_q;
	logic [7:0]       type_out_q;

	logic              pop;
	logic [TICK_W-1:0] tick_inc;
	logic              timed_out;
	logic [7:0]        count_adj;
	logic [2:0]        finish_code;
	logic              emit;
	logic              emit_status;
	logic [2:0]        emit_code;
	logic              clear_all;

	assign pop_ready = !out_valid_q || out_ch.ready;
	assign pop = pop_valid && pop_ready;

	assign tick_inc = (tick_q != {TICK_W{1'b1}}) ? tick_q + 1'b1 : tick_q;
	assign timed_out = (tick_inc >= timeout_ticks);
	assign count_adj = {1'b0, count_q} + 8'd31;

	always_comb begin
		if (count_q == '0) begin
			finish_code = ST_SHORTER;
		end else if (len_q < count_adj) begin
			finish_code = ST_SHORTER;
		end else if (len_q != count_adj) begin
			finish_code = ST_LONGER;
		end else if (last_q != check_value(sum_prev_q)) begin
			finish_code = ST_BAD_SUM;
		end else begin
			finish_code = ST_OK;
		end
	end

	always_comb begin
		emit = 1'b0;
		emit_status = 1'b0;
		emit_code = ST_OK;
		if (pop_item.func == FUNC_TICK) begin
			if (timed_out) begin
				emit = 1'b1;
				emit_status = 1'b1;
				emit_code = ST_TIMEOUT;
			end
		end else if (in_packet_q) begin
			emit = 1'b1;
			if (pop_item.is_end) begin
				emit_status = 1'b1;
				emit_code = finish_code;
			end else if (count_q >= POS_W'(MAX_BYTES)) begin
				emit_status = 1'b1;
				emit_code = ST_TOO_LONG;
			end
		end
	end

	assign clear_all = emit_status ||
		(pop_item.func == FUNC_BYTE && !in_packet_q && pop_item.is_start);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			count_q <= '0;
			tick_q <= '0;
			sum_q <= '0;
			sum_prev_q <= '0;
			last_q <= '0;
			len_q <= '0;
			seq_q <= '0;
			type_q <= '0;
		end else if (pop) begin
			if (clear_all) begin
				in_packet_q <= !emit_status;
				count_q <= '0;
				tick_q <= '0;
				sum_q <= '0;
				sum_prev_q <= '0;
				last_q <= '0;
				len_q <= '0;
				seq_q <= '0;
				type_q <= '0;
			end else if (pop_item.func == FUNC_TICK) begin
				tick_q <= tick_inc;
			end else if (in_packet_q) begin
				tick_q <= '0;
				case (count_q)
					POS_W'(0): len_q <= pop_item.data_byte;
					POS_W'(1): seq_q <= pop_item.data_byte;
					POS_W'(2): type_q <= pop_item.data_byte;
					default: ;
				endcase
				sum_prev_q <= sum_q;
				sum_q <= sum_q + pop_item.data_byte;
				last_q <= pop_item.data_byte;
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			if (emit_status) begin
				kind_q <= KIND_STATUS;
				position_q <= '0;
				byte_value_q <= '0;
				status_q <= emit_code;
				seq_out_q <= seq_q;
				type_out_q <= type_q;
			end else begin
				kind_q <= KIND_BYTE;
				position_q <= count_q;
				byte_value_q <= pop_item.data_byte;
				status_q <= ST_OK;
				seq_out_q <= '0;
				type_out_q <= '0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.kind = kind_q;
	assign out_ch.position = position_q;
	assign out_ch.byte_value = byte_value_q;
	assign out_ch.status = status_q;
	assign out_ch.packet_seq = seq_out_q;
	assign out_ch.packet_type = type_out_q;
endmodule

// File: hw/rtl/kermit_packet_deframer.sv
// Kermit packet deframer, type-1 checksum: front end, two-entry queue, back end.
// A request that yields a result is held in a queue entry, then in the result register.
// Throughput: one request per cycle, set by the back end, while out_ch accepts each result.
// Reset (arst_n low, asynchronous): hunting, packet state cleared, queue empty,
// registers back to timeout 100, start 0x01, end 13. No clearing pass.
module kermit_packet_deframer (
	input  logic         clk,
	input  logic         arst_n,
	kpd_item_if.sink     in_ch,
	kpd_result_if.source out_ch,
	kpd_cfg_if.sink      cfg_ch
);
	import kpd_pkg::*;

	kpd_item_t         push_item;
	logic              push_valid;
	logic              push_ready;
	kpd_item_t         pop_item;
	logic              pop_valid;
	logic              pop_ready;
	logic [TICK_W-1:0] timeout_ticks;

	kpd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.cfg_ch        (cfg_ch),
		.push_item     (push_item),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.timeout_ticks (timeout_ticks)
	);

	kpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	kpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_item      (pop_item),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.timeout_ticks (timeout_ticks),
		.out_ch        (out_ch)
	);
endmodule
